// ----- src/lbfd_pkg.sv -----
// Shared types, register codes and constants for the light beacon frame decoder.
// No dependencies; every other file imports this package.
package lbfd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = 28;
  localparam int FRAME_BITS  = 14;
  localparam int BEACONS     = 3;
  localparam int BEACON_IDX_W = 2;
  localparam int CODE_BITS   = 8;
  localparam int MATCH_BITS  = 4;

  localparam logic [FRAME_BITS-1:0] FRAME_CAP = 14'd8192;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

  localparam int SYNC_BITS_DEF     = 8;
  localparam int ID_BITS_DEF       = 8;
  localparam int LEVEL_SAMPLES_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON0_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON1_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON2_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH_BITS = 3'd5;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = 12'd1800;
  localparam logic [CODE_BITS-1:0]   SYNC_RST      = 8'd170;
  localparam logic [CODE_BITS-1:0]   BEACON0_RST   = 8'd10;
  localparam logic [CODE_BITS-1:0]   BEACON1_RST   = 8'd45;
  localparam logic [CODE_BITS-1:0]   BEACON2_RST   = 8'd25;
  localparam logic [MATCH_BITS-1:0]  MIN_MATCH_RST = 4'd8;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] beacon0_level;
    logic [SAMPLE_BITS-1:0] beacon1_level;
    logic [SAMPLE_BITS-1:0] beacon2_level;
    logic [FRAME_BITS-1:0]  beacon0_frames;
    logic [FRAME_BITS-1:0]  beacon1_frames;
    logic [FRAME_BITS-1:0]  beacon2_frames;
  } out_item_t;

  typedef struct packed {
    logic                    shift;
    logic                    eval;
    logic                    div_start;
    logic                    div_store;
    logic                    load_out;
    logic                    clear;
    logic [BEACON_IDX_W-1:0] beacon;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// ----- src/lbfd_div.sv -----
// Restoring divider: sum over divisor, one quotient bit per cycle.
// Depends on lbfd_pkg. Quotient is known to fit SAMPLE_BITS; zero divisor gives 0.
module lbfd_div
  import lbfd_pkg::*;
#(
  parameter int DIVR_W = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SUM_BITS-1:0]    dividend,
  input  logic [DIVR_W-1:0]      divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  localparam int DSH_W = DIVR_W + SAMPLE_BITS - 1;
  localparam int CMP_W = (DSH_W > SUM_BITS) ? DSH_W : SUM_BITS;
  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic                   busy;
  logic                   zero;
  logic [CMP_W-1:0]       rem;
  logic [CMP_W-1:0]       dsh;
  logic [SAMPLE_BITS-1:0] quo;
  logic [CNT_W-1:0]       cnt;
  logic                   fits;

  assign fits     = (rem >= dsh);
  assign quotient = zero ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // First step tests the top quotient bit: divisor aligned to bit SAMPLE_BITS-1.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= CMP_W'(dividend);
      dsh  <= CMP_W'({divisor, {(SAMPLE_BITS-1){1'b0}}});
      quo  <= '0;
      cnt  <= CNT_W'(SAMPLE_BITS - 1);
      zero <= (divisor == '0);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[SAMPLE_BITS-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- src/lbfd_datapath.sv -----
// Datapath: config registers, sample and bit windows, frame match, per-beacon sums
// and counts, shared divider and output register. Depends on lbfd_pkg and lbfd_div.
module lbfd_datapath
  import lbfd_pkg::*;
#(
  parameter int SYNC_BITS     = SYNC_BITS_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int LEVEL_SAMPLES = LEVEL_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output out_item_t             out_data
);

  localparam int FRAME_LEN = SYNC_BITS + ID_BITS + LEVEL_SAMPLES;
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int ADD_W     = SAMPLE_BITS + $clog2(LEVEL_SAMPLES);
  localparam int DIVR_W    = FRAME_BITS + $clog2(LEVEL_SAMPLES);
  localparam int SYNC_EXT  = (SYNC_BITS > CODE_BITS) ? SYNC_BITS : CODE_BITS;
  localparam int ID_EXT    = (ID_BITS > CODE_BITS) ? ID_BITS : CODE_BITS;
  localparam int SCORE_W   = $clog2(16 + 1);

  logic [SAMPLE_BITS-1:0] bit_threshold;
  logic [CODE_BITS-1:0]   sync_pattern;
  logic [CODE_BITS-1:0]   beacon_code [BEACONS];
  logic [MATCH_BITS-1:0]  min_match_bits;

  logic [SAMPLE_BITS-1:0] sample_window [FRAME_LEN];
  logic [FRAME_LEN-1:0]   bit_window;
  logic [FILL_W-1:0]      fill_count;
  logic [SUM_BITS-1:0]    level_sums   [BEACONS];
  logic [FRAME_BITS-1:0]  frame_counts [BEACONS];
  logic [SAMPLE_BITS-1:0] level_stage  [BEACONS];

  logic [SYNC_BITS-1:0]      sync_got;
  logic [SYNC_BITS-1:0]      sync_want;
  logic [SYNC_EXT-1:0]       sync_ext;
  logic [ID_BITS-1:0]        id_got;
  logic [ID_BITS-1:0]        id_want  [BEACONS];
  logic [ID_EXT-1:0]         id_ext   [BEACONS];
  logic                      sync_ok;
  logic [BEACONS-1:0]        id_ok;
  logic                      hit;
  logic [BEACON_IDX_W-1:0]   hit_idx;
  logic [ADD_W-1:0]          add;
  logic [SUM_BITS:0]         sum_wide;
  logic [SUM_BITS-1:0]       sum_next;
  logic                      take;
  logic                      div_done;
  logic [SAMPLE_BITS-1:0]    div_quo;
  logic [DIVR_W-1:0]         divisor;

  // Frame fields sit in the bit window with the earliest bit highest.
  assign sync_got  = bit_window[FRAME_LEN-1 -: SYNC_BITS];
  assign id_got    = bit_window[LEVEL_SAMPLES+ID_BITS-1 -: ID_BITS];
  assign sync_ext  = SYNC_EXT'(sync_pattern);
  assign sync_want = sync_ext[SYNC_BITS-1:0];
  assign sync_ok   = (SCORE_W'($countones(~(sync_got ^ sync_want))) >=
                      SCORE_W'(min_match_bits));

  always_comb begin
    for (int b = 0; b < BEACONS; b++) begin
      id_ext[b]  = ID_EXT'(beacon_code[b]);
      id_want[b] = id_ext[b][ID_BITS-1:0];
      id_ok[b]   = (SCORE_W'($countones(~(id_got ^ id_want[b]))) >=
                    SCORE_W'(min_match_bits));
    end
  end

  // First matching code wins.
  always_comb begin
    hit     = 1'b1;
    hit_idx = '0;
    if (id_ok[0]) begin
      hit_idx = BEACON_IDX_W'(0);
    end else if (id_ok[1]) begin
      hit_idx = BEACON_IDX_W'(1);
    end else if (id_ok[2]) begin
      hit_idx = BEACON_IDX_W'(2);
    end else begin
      hit = 1'b0;
    end
  end

  // Sum the newest LEVEL_SAMPLES-1 level samples.
  always_comb begin
    add = '0;
    for (int k = 0; k < LEVEL_SAMPLES - 1; k++) begin
      add = add + ADD_W'(sample_window[k]);
    end
  end

  assign sum_wide = {1'b0, level_sums[hit_idx]} + (SUM_BITS+1)'(add);
  assign sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
  assign take     = cmd.eval && (fill_count == FILL_W'(FRAME_LEN)) && sync_ok && hit &&
                    (frame_counts[hit_idx] < FRAME_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold  <= THRESHOLD_RST;
      sync_pattern   <= SYNC_RST;
      beacon_code[0] <= BEACON0_RST;
      beacon_code[1] <= BEACON1_RST;
      beacon_code[2] <= BEACON2_RST;
      min_match_bits <= MIN_MATCH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BIT_THRESHOLD:  bit_threshold  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_SYNC_PATTERN:   sync_pattern   <= cfg_data[CODE_BITS-1:0];
        CFG_BEACON0_CODE:   beacon_code[0] <= cfg_data[CODE_BITS-1:0];
        CFG_BEACON1_CODE:   beacon_code[1] <= cfg_data[CODE_BITS-1:0];
        CFG_BEACON2_CODE:   beacon_code[2] <= cfg_data[CODE_BITS-1:0];
        CFG_MIN_MATCH_BITS: min_match_bits <= cfg_data[MATCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window contents need no clear: no frame is tested before the fill count is full.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      sample_window[0] <= in_data.sample;
      for (int k = 1; k < FRAME_LEN; k++) begin
        sample_window[k] <= sample_window[k-1];
      end
      bit_window <= {bit_window[FRAME_LEN-2:0], (in_data.sample > bit_threshold)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill_count <= '0;
      for (int b = 0; b < BEACONS; b++) begin
        level_sums[b]   <= '0;
        frame_counts[b] <= '0;
      end
    end else begin
      if (cmd.shift && (fill_count != FILL_W'(FRAME_LEN))) begin
        fill_count <= fill_count + 1'b1;
      end
      if (take) begin
        level_sums[hit_idx]   <= sum_next;
        frame_counts[hit_idx] <= frame_counts[hit_idx] + 1'b1;
      end
    end
  end

  assign divisor = DIVR_W'(frame_counts[cmd.beacon]) * DIVR_W'(LEVEL_SAMPLES - 1);

  lbfd_div #(
    .DIVR_W (DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (level_sums[cmd.beacon]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      level_stage[cmd.beacon] <= div_quo;
    end
    if (cmd.load_out) begin
      out_data.beacon0_level  <= level_stage[0];
      out_data.beacon1_level  <= level_stage[1];
      out_data.beacon2_level  <= level_stage[2];
      out_data.beacon0_frames <= frame_counts[0];
      out_data.beacon1_frames <= frame_counts[1];
      out_data.beacon2_frames <= frame_counts[2];
    end
  end

endmodule

// ----- src/lbfd_ctrl.sv -----
// Controller: input handshake, per-sample evaluation, end-of-buffer divide sequence
// and output valid. Depends on lbfd_pkg.
module lbfd_ctrl
  import lbfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_RUN    = 4'b0001,
    S_DSTART = 4'b0010,
    S_DWAIT  = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic                    pend, pend_next;
  logic                    pend_last, pend_last_next;
  logic [BEACON_IDX_W-1:0] beacon, beacon_next;
  logic                    out_valid_next;
  logic                    accept;

  // Hold off input outside the run state and while the final sample of a buffer still awaits evaluation.
  assign in_ready       = (state == S_RUN) && !(pend && pend_last);
  assign accept         = in_valid && in_ready;
  assign pend_next      = accept;
  assign pend_last_next = accept && in_last;

  always_comb begin
    state_next   = state;
    beacon_next  = beacon;
    cmd          = '0;
    cmd.beacon   = beacon;
    cmd.shift    = accept;
    cmd.eval     = (state == S_RUN) && pend;
    unique case (state)
      S_RUN: begin
        if (pend && pend_last) begin
          beacon_next = '0;
          state_next  = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (beacon == BEACON_IDX_W'(BEACONS - 1)) begin
            state_next = S_FLUSH;
          end else begin
            beacon_next = beacon + 1'b1;
            state_next  = S_DSTART;
          end
        end
      end
      S_FLUSH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      beacon    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      pend_last <= pend_last_next;
      beacon    <= beacon_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/light_beacon_frame_decoder_unit.sv -----
// Top level of the light beacon frame decoder: controller plus datapath.
// Depends on lbfd_pkg, lbfd_ctrl, lbfd_datapath (which holds lbfd_div).
//
//  channel | signals                          | payload
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid / in_ready              | in_data: sample, end_of_buffer
//  out     | out_valid / out_ready            | out_data: levels and frame counts
//  cfg     | cfg_valid / cfg_ready (always 1) | cfg_index, cfg_data
//
// One sample per cycle while input is not stalled: each sample is shifted in at acceptance and matched and
// summed in the following cycle, overlapped with the next acceptance.
// After an end_of_buffer sample, input stalls: the sample is evaluated, then three averages
// go in turn through one shared divider (one quotient bit per cycle), then the output
// is loaded and the sums and counts are cleared.
// The load waits further while a previous result has not been taken.
// Reset is synchronous and restores the register defaults and empty sums.
module light_beacon_frame_decoder_unit
  import lbfd_pkg::*;
#(
  parameter int SYNC_BITS     = SYNC_BITS_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int LEVEL_SAMPLES = LEVEL_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lbfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.end_of_buffer),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lbfd_datapath #(
    .SYNC_BITS     (SYNC_BITS),
    .ID_BITS       (ID_BITS),
    .LEVEL_SAMPLES (LEVEL_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- src/lbfd_checker.sv -----
// Port-level checks for the light beacon frame decoder, bound to the top level.
// Depends on lbfd_pkg.
module lbfd_props
  import lbfd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input closes right after the last sample of a buffer.
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.end_of_buffer |=> !in_ready)
    else $error("input open after end of buffer");

  // A new result appears only while input is held off.
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while taking input");

  // A beacon with no frames reports level zero.
  a_zero_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.beacon0_frames != '0 || out_data.beacon0_level == '0) &&
      (out_data.beacon1_frames != '0 || out_data.beacon1_level == '0) &&
      (out_data.beacon2_frames != '0 || out_data.beacon2_level == '0))
    else $error("nonzero level without frames");

  // Frame counts never pass the cap.
  a_frame_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.beacon0_frames <= FRAME_CAP &&
                  out_data.beacon1_frames <= FRAME_CAP &&
                  out_data.beacon2_frames <= FRAME_CAP)
    else $error("frame count above cap");

endmodule

bind light_beacon_frame_decoder_unit lbfd_props u_lbfd_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
